>>> hw/rtl/sm83_instruction_subset_core_defines.svh
// Assertion macros used by the checker file.
`ifndef SM83_INSTRUCTION_SUBSET_CORE_DEFINES_SVH
`define SM83_INSTRUCTION_SUBSET_CORE_DEFINES_SVH
`define SM83_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("sm83 check failed");
`define SM83_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("sm83 check failed");
`endif

>>> hw/rtl/sm83_pkg.sv
// Shared types and constants of the instruction subset core.
`default_nettype none
package sm83_pkg;
  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_READ  = 2'd1;
  localparam logic [1:0] ACC_WRITE = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_WAIT   = 2'd1;
  localparam logic [1:0] ST_HALT   = 2'd2;
  localparam logic [1:0] ST_UNK    = 2'd3;
  localparam logic [15:0] PC_RESET = 16'h0100;
  localparam logic [15:0] IE_RESET = 16'hFFFF;
  localparam logic [7:0] OP_NOP  = 8'h00;
  localparam logic [7:0] OP_HALT = 8'h76;
  localparam logic [7:0] OP_JR   = 8'h18;
  localparam logic [7:0] OP_JP   = 8'hC3;
  localparam logic [7:0] OP_DI   = 8'hF3;
  localparam logic [7:0] OP_EI   = 8'hFB;
  localparam logic [7:0] OP_LDHW = 8'hE0;
  localparam logic [7:0] OP_LDHR = 8'hF0;
  localparam logic [7:0] OP_LDAW = 8'hEA;
  localparam logic [7:0] OP_LDAR = 8'hFA;
  localparam logic [7:0] OP_INCM = 8'h34;
  localparam logic [7:0] OP_DECM = 8'h35;
  localparam logic [7:0] OP_ALUMAX = 8'hB7;
  localparam int unsigned RB_A = 6;
  localparam int unsigned RB_H = 4;
  localparam int unsigned RB_L = 5;

  typedef struct packed {
    logic [1:0]  access;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [15:0] program_counter;
    logic [1:0]  status;
    logic [3:0]  flag_bits;
  } result_t;

  typedef struct packed {
    logic [7:0] res;
    logic [3:0] flags;
  } alu_out_t;

  function automatic logic [2:0] reg_idx(input logic [2:0] c);
    return (c == 3'd7 || c == 3'd6) ? 3'(RB_A) : c;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/sm83_alu.sv
// Eight-bit ALU with INC and DEC producing result and flags.
`default_nettype none
module sm83_alu (
  input  wire logic [2:0] op_sel,
  input  wire logic       is_incdec,
  input  wire logic       dec,
  input  wire logic [7:0] a,
  input  wire logic [7:0] b,
  input  wire logic [3:0] flags_in,
  output sm83_pkg::alu_out_t out
);
  logic       c;
  logic [8:0] s;
  logic [4:0] h;
  logic [7:0] r;
  logic [3:0] f;
  always_comb begin
    c = flags_in[0] & op_sel[0];
    s = '0;
    h = '0;
    r = '0;
    f = '0;
    if (is_incdec) begin
      r = dec ? b - 8'd1 : b + 8'd1;
      f[0] = flags_in[0];
      f[2] = dec;
      f[1] = dec ? (b[3:0] == 4'd0) : (b[3:0] == 4'hF);
    end else begin
      unique case (op_sel)
        3'd0, 3'd1: begin
          s = {1'b0, a} + {1'b0, b} + {8'd0, c};
          h = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c};
          r = s[7:0];
          f[1] = h[4];
          f[0] = s[8];
        end
        3'd2, 3'd3: begin
          s = {1'b0, a} - {1'b0, b} - {8'd0, c};
          h = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c};
          r = s[7:0];
          f[2] = 1'b1;
          f[1] = h[4];
          f[0] = s[8];
        end
        3'd4: begin
          r = a & b;
          f[1] = 1'b1;
        end
        3'd5: r = a ^ b;
        default: r = a | b;
      endcase
    end
    f[3] = (r == 8'd0);
    out.res = r;
    out.flags = f;
  end
endmodule
`default_nettype wire

>>> hw/rtl/sm83_instruction_subset_core.sv
// Top level of the SM83 instruction subset core.
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_kind, in_opcode, in_operand_*, in_read_data
// out     | output    | out_valid, out_ready, out_access .. out_flag_bits
// cfg     | input     | cfg_we, cfg_wdata
// Each item is executed in the cycle it is accepted and its result is registered.
// One item per cycle is sustained while out_ready is high; the result register is the only stage.
// A new item is accepted when the result register is empty or being taken.
// Reset is synchronous; it clears the register file, flags, SP and state and sets PC to 0x0100.
`default_nettype none
module sm83_instruction_subset_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_opcode,
  input  wire logic [7:0]  in_operand_low,
  input  wire logic [7:0]  in_operand_high,
  input  wire logic [7:0]  in_read_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_access,
  output logic [15:0]      out_address,
  output logic [7:0]       out_write_data,
  output logic [15:0]      out_program_counter,
  output logic [1:0]       out_status,
  output logic [3:0]       out_flag_bits
);
  logic [7:0]  rf_r [7];
  logic [7:0]  rf_nxt [7];
  logic [3:0]  flag_r, flag_nxt;
  logic [15:0] sp_r, sp_nxt, pc_r, pc_nxt, ie_r;
  logic        pend_r, pend_nxt, halt_r, halt_nxt;
  logic [7:0]  pop_r, pop_nxt;
  logic        valid_r;
  sm83_pkg::result_t res_r, res_nxt;
  logic        take;

  logic [2:0]  alu_sel;
  logic        alu_incdec, alu_dec;
  logic [7:0]  alu_b;
  sm83_pkg::alu_out_t alu_o;

  logic [1:0]  x;
  logic [2:0]  y, z;
  logic [15:0] imm, hl, rpv, bc, de;
  logic        cond;

  assign in_ready = !valid_r || out_ready;
  assign take = in_valid && in_ready;
  assign x = in_opcode[7:6];
  assign y = in_opcode[5:3];
  assign z = in_opcode[2:0];
  assign imm = {in_operand_high, in_operand_low};
  assign bc = {rf_r[0], rf_r[1]};
  assign de = {rf_r[2], rf_r[3]};
  assign hl = {rf_r[sm83_pkg::RB_H], rf_r[sm83_pkg::RB_L]};

  sm83_alu u_alu (
    .op_sel(alu_sel), .is_incdec(alu_incdec), .dec(alu_dec),
    .a(rf_r[sm83_pkg::RB_A]), .b(alu_b), .flags_in(flag_r), .out(alu_o)
  );

  always_comb begin
    unique case (y[1:0])
      2'd0: cond = !flag_r[3];
      2'd1: cond = flag_r[3];
      2'd2: cond = !flag_r[0];
      default: cond = flag_r[0];
    endcase
    unique case (y[2:1])
      2'd0: rpv = bc;
      2'd1: rpv = de;
      2'd2: rpv = hl;
      default: rpv = sp_r;
    endcase
  end

  always_comb begin
    logic rd;
    logic [15:0] v;
    rd = 1'b0;
    v = '0;
    rf_nxt = rf_r;
    flag_nxt = flag_r;
    sp_nxt = sp_r;
    pc_nxt = pc_r;
    pend_nxt = pend_r;
    pop_nxt = pop_r;
    halt_nxt = halt_r;
    alu_sel = y;
    alu_incdec = 1'b0;
    alu_dec = 1'b0;
    alu_b = rf_r[sm83_pkg::reg_idx(z)];
    res_nxt = '0;
    if (halt_r) begin
      res_nxt.status = sm83_pkg::ST_HALT;
    end else if (in_kind) begin
      alu_sel = pop_r[5:3];
      alu_b = in_read_data;
      alu_incdec = (pop_r == sm83_pkg::OP_INCM) || (pop_r == sm83_pkg::OP_DECM);
      alu_dec = pop_r[0];
      if (pend_r) begin
        pend_nxt = 1'b0;
        if (alu_incdec) begin
          flag_nxt = alu_o.flags;
          res_nxt.access = sm83_pkg::ACC_WRITE;
          res_nxt.address = hl;
          res_nxt.write_data = alu_o.res;
        end else if (pop_r[7:6] == 2'd2) begin
          rf_nxt[sm83_pkg::RB_A] = alu_o.res;
          flag_nxt = alu_o.flags;
        end else if (pop_r[7:6] == 2'd1) begin
          rf_nxt[sm83_pkg::reg_idx(pop_r[5:3])] = in_read_data;
        end else begin
          rf_nxt[sm83_pkg::RB_A] = in_read_data;
        end
      end
    end else begin
      pend_nxt = 1'b0;
      if (in_opcode == sm83_pkg::OP_HALT) begin
        halt_nxt = 1'b1;
        res_nxt.status = sm83_pkg::ST_HALT;
      end else if (x == 2'd1) begin
        pc_nxt = pc_r + 16'd1;
        if (z == 3'd6) begin
          rd = 1'b1;
          res_nxt.address = hl;
        end else if (y == 3'd6) begin
          res_nxt.access = sm83_pkg::ACC_WRITE;
          res_nxt.address = hl;
          res_nxt.write_data = rf_r[sm83_pkg::reg_idx(z)];
        end else begin
          rf_nxt[sm83_pkg::reg_idx(y)] = rf_r[sm83_pkg::reg_idx(z)];
        end
      end else if (x == 2'd2 && in_opcode <= sm83_pkg::OP_ALUMAX) begin
        pc_nxt = pc_r + 16'd1;
        if (z == 3'd6) begin
          rd = 1'b1;
          res_nxt.address = hl;
        end else begin
          rf_nxt[sm83_pkg::RB_A] = alu_o.res;
          flag_nxt = alu_o.flags;
        end
      end else if (in_opcode == sm83_pkg::OP_NOP) begin
        pc_nxt = pc_r + 16'd1;
      end else if (x == 2'd0 && z == 3'd3) begin
        v = y[0] ? rpv - 16'd1 : rpv + 16'd1;
        unique case (y[2:1])
          2'd0: {rf_nxt[0], rf_nxt[1]} = v;
          2'd1: {rf_nxt[2], rf_nxt[3]} = v;
          2'd2: {rf_nxt[sm83_pkg::RB_H], rf_nxt[sm83_pkg::RB_L]} = v;
          default: sp_nxt = v;
        endcase
        pc_nxt = pc_r + 16'd1;
      end else if (x == 2'd0 && (z == 3'd4 || z == 3'd5)) begin
        pc_nxt = pc_r + 16'd1;
        if (y == 3'd6) begin
          rd = 1'b1;
          res_nxt.address = hl;
        end else begin
          alu_incdec = 1'b1;
          alu_dec = z[0];
          alu_b = rf_r[sm83_pkg::reg_idx(y)];
          rf_nxt[sm83_pkg::reg_idx(y)] = alu_o.res;
          flag_nxt = alu_o.flags;
        end
      end else if (x == 2'd0 && z == 3'd6) begin
        pc_nxt = pc_r + 16'd2;
        if (y == 3'd6) begin
          res_nxt.access = sm83_pkg::ACC_WRITE;
          res_nxt.address = hl;
          res_nxt.write_data = in_operand_low;
        end else begin
          rf_nxt[sm83_pkg::reg_idx(y)] = in_operand_low;
        end
      end else if (x == 2'd0 && z == 3'd1 && !y[0]) begin
        unique case (y[2:1])
          2'd0: {rf_nxt[0], rf_nxt[1]} = imm;
          2'd1: {rf_nxt[2], rf_nxt[3]} = imm;
          2'd2: {rf_nxt[sm83_pkg::RB_H], rf_nxt[sm83_pkg::RB_L]} = imm;
          default: sp_nxt = imm;
        endcase
        pc_nxt = pc_r + 16'd3;
      end else if (x == 2'd0 && z == 3'd2) begin
        res_nxt.address = rpv;
        if (y[0]) begin
          rd = 1'b1;
        end else begin
          res_nxt.access = sm83_pkg::ACC_WRITE;
          res_nxt.write_data = rf_r[sm83_pkg::RB_A];
        end
        if (y[2:1] == 2'd2) begin
          {rf_nxt[sm83_pkg::RB_H], rf_nxt[sm83_pkg::RB_L]} = hl + 16'd1;
        end else if (y[2:1] == 2'd3) begin
          res_nxt.address = hl;
          {rf_nxt[sm83_pkg::RB_H], rf_nxt[sm83_pkg::RB_L]} = hl - 16'd1;
        end
        pc_nxt = pc_r + 16'd1;
      end else if (in_opcode == sm83_pkg::OP_JR || (x == 2'd0 && z == 3'd0 && y[2])) begin
        if (in_opcode == sm83_pkg::OP_JR || cond) begin
          pc_nxt = pc_r + 16'd2 + {{8{in_operand_low[7]}}, in_operand_low};
        end else begin
          pc_nxt = pc_r + 16'd2;
        end
      end else if (in_opcode == sm83_pkg::OP_JP || (x == 2'd3 && z == 3'd2 && !y[2])) begin
        pc_nxt = (in_opcode == sm83_pkg::OP_JP || cond) ? imm : pc_r + 16'd3;
      end else if (in_opcode == sm83_pkg::OP_DI || in_opcode == sm83_pkg::OP_EI) begin
        res_nxt.access = sm83_pkg::ACC_WRITE;
        res_nxt.address = ie_r;
        res_nxt.write_data = {7'd0, in_opcode == sm83_pkg::OP_EI};
        pc_nxt = pc_r + 16'd1;
      end else if (in_opcode == sm83_pkg::OP_LDHW || in_opcode == sm83_pkg::OP_LDHR) begin
        res_nxt.address = {8'hFF, in_operand_low};
        if (in_opcode == sm83_pkg::OP_LDHR) begin
          rd = 1'b1;
        end else begin
          res_nxt.access = sm83_pkg::ACC_WRITE;
          res_nxt.write_data = rf_r[sm83_pkg::RB_A];
        end
        pc_nxt = pc_r + 16'd2;
      end else if (in_opcode == sm83_pkg::OP_LDAW || in_opcode == sm83_pkg::OP_LDAR) begin
        res_nxt.address = imm;
        if (in_opcode == sm83_pkg::OP_LDAR) begin
          rd = 1'b1;
        end else begin
          res_nxt.access = sm83_pkg::ACC_WRITE;
          res_nxt.write_data = rf_r[sm83_pkg::RB_A];
        end
        pc_nxt = pc_r + 16'd3;
      end else begin
        halt_nxt = 1'b1;
        res_nxt.status = sm83_pkg::ST_UNK;
      end
      if (rd) begin
        res_nxt.access = sm83_pkg::ACC_READ;
        res_nxt.status = sm83_pkg::ST_WAIT;
        pend_nxt = 1'b1;
        pop_nxt = in_opcode;
      end
    end
    res_nxt.program_counter = pc_nxt;
    res_nxt.flag_bits = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) begin
        rf_r[i] <= '0;
      end
      flag_r <= '0;
      sp_r <= '0;
      pc_r <= sm83_pkg::PC_RESET;
      pend_r <= 1'b0;
      pop_r <= '0;
      halt_r <= 1'b0;
      ie_r <= sm83_pkg::IE_RESET;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ie_r <= cfg_wdata;
      end
      if (take) begin
        rf_r <= rf_nxt;
        flag_r <= flag_nxt;
        sp_r <= sp_nxt;
        pc_r <= pc_nxt;
        pend_r <= pend_nxt;
        pop_r <= pop_nxt;
        halt_r <= halt_nxt;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_access = res_r.access;
  assign out_address = res_r.address;
  assign out_write_data = res_r.write_data;
  assign out_program_counter = res_r.program_counter;
  assign out_status = res_r.status;
  assign out_flag_bits = res_r.flag_bits;
endmodule
`default_nettype wire

>>> hw/rtl/sm83_checker.sv
// Port-level checker for the instruction subset core, with its bind.
`default_nettype none
`include "sm83_instruction_subset_core_defines.svh"
module sm83_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_access,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_write_data
);
  `SM83_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_valid && in_ready, out_valid)
  `SM83_ASSERT_IMPL(a_ready_when_free, clk, rst_n, !out_valid || out_ready, in_ready)
  `SM83_ASSERT_IMPL(a_wait_means_read, clk, rst_n, out_valid && out_status == sm83_pkg::ST_WAIT,
                    out_access == sm83_pkg::ACC_READ)
  `SM83_ASSERT_IMPL(a_no_access_no_data, clk, rst_n,
                    out_valid && out_access != sm83_pkg::ACC_WRITE, out_write_data == 8'd0)
endmodule
bind sm83_instruction_subset_core sm83_checker u_sm83_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_access(out_access),
  .out_status(out_status), .out_write_data(out_write_data)
);
`default_nettype wire
